>>> design/nsr_pkg.sv
// ----------------------------------------------------------------------------
// Newton square root package
// Shared types and constants for the fixed-point Newton square root block.
// ----------------------------------------------------------------------------
package nsr_pkg;

  // Configuration register port.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_TOLERANCE  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ITER_LIMIT = 1'd1;

  localparam int unsigned TolW = 16;
  localparam int unsigned LimW = 6;

  localparam logic [TolW-1:0] TOL_RESET = 16'd1;
  localparam logic [LimW-1:0] LIM_RESET = 6'd55;

  // Stream payload widths.
  localparam int unsigned RadicandW = 32;
  localparam int unsigned RootW     = 32;
  localparam int unsigned OutDataW  = 40;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIFF,
    ST_NEG,
    ST_SAT,
    ST_DIV,
    ST_UPD,
    ST_CHG,
    ST_OUT
  } nsr_state_e;

  typedef struct packed {
    logic idle;
    logic done;
  } nsr_status_t;

endpackage

>>> design/nsr_addsub.sv
// ----------------------------------------------------------------------------
// Shared adder-subtractor
// The single arithmetic unit used for every multiply, divide and update step.
// ----------------------------------------------------------------------------
module nsr_addsub #(
  parameter int unsigned WIDTH = 66
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic             sub_i,
  output logic [WIDTH-1:0] sum_o
);

  assign sum_o = sub_i ? (a_i - b_i) : (a_i + b_i);

endmodule

>>> design/nsr_core.sv
// ----------------------------------------------------------------------------
// Newton square root sequencer
// Runs shift-add multiply, restoring divide and estimate update on one
// shared adder-subtractor, one step per cycle.
// ----------------------------------------------------------------------------
module nsr_core #(
  parameter int unsigned INT_BITS  = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [INT_BITS+FRAC_BITS-1:0]         radicand_i,
  input  logic [nsr_pkg::TolW-1:0]              tol_i,
  input  logic [nsr_pkg::LimW-1:0]              lim_i,
  input  logic                                  out_free_i,
  output nsr_pkg::nsr_status_t                  status_o,
  output logic [INT_BITS+FRAC_BITS-1:0]         root_o,
  output logic [nsr_pkg::LimW-1:0]              iters_o,
  output logic                                  conv_o
);

  localparam int unsigned W  = INT_BITS + FRAC_BITS;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned MB = W + INT_BITS;
  localparam int unsigned UW = 2 * W + 2;
  localparam int unsigned CW = $clog2(W);
  localparam logic [W-1:0] OneFx = W'(1) << FRAC_BITS;
  localparam logic [W-1:0] WMask = {W{1'b1}};
  localparam logic [CW-1:0] LastBit = CW'(W - 1);

  nsr_pkg::nsr_state_e state_q, state_d;

  logic [W-1:0]               a_q, a_d;
  logic [W-1:0]               x_q, x_d;
  logic [W-1:0]               nx_q, nx_d;
  logic [PW-1:0]              acc_q, acc_d;
  logic [MB-1:0]              mag_q, mag_d;
  logic [W:0]                 rem_q, rem_d;
  logic [W-1:0]               nbits_q, nbits_d;
  logic [W-1:0]               quot_q, quot_d;
  logic                       neg_q, neg_d;
  logic                       conv_q, conv_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [nsr_pkg::LimW-1:0]   iters_q, iters_d;

  logic [UW-1:0]              unit_a, unit_b, unit_sum;
  logic                       unit_sub;
  logic [W:0]                 den;
  logic [W-1:0]               x_bit_term;
  logic [nsr_pkg::LimW-1:0]   lim_eff;
  logic [nsr_pkg::LimW-1:0]   iters_inc;
  logic                       tol_met;
  logic                       done;

  nsr_addsub #(
    .WIDTH(UW)
  ) u_addsub (
    .a_i  (unit_a),
    .b_i  (unit_b),
    .sub_i(unit_sub),
    .sum_o(unit_sum)
  );

  assign den        = {x_q, 1'b0};
  assign x_bit_term = x_q[cnt_q] ? x_q : '0;
  assign lim_eff    = (lim_i == '0) ? nsr_pkg::LimW'(1) : lim_i;
  assign iters_inc  = iters_q + nsr_pkg::LimW'(1);
  assign tol_met    = {{nsr_pkg::TolW{1'b0}}, unit_sum[W-1:0]} <= {{W{1'b0}}, tol_i};

  always_comb begin
    state_d  = state_q;
    a_d      = a_q;
    x_d      = x_q;
    nx_d     = nx_q;
    acc_d    = acc_q;
    mag_d    = mag_q;
    rem_d    = rem_q;
    nbits_d  = nbits_q;
    quot_d   = quot_q;
    neg_d    = neg_q;
    conv_d   = conv_q;
    cnt_d    = cnt_q;
    iters_d  = iters_q;
    unit_a   = '0;
    unit_b   = '0;
    unit_sub = 1'b0;
    done     = 1'b0;

    unique case (state_q)
      nsr_pkg::ST_IDLE: begin
        if (start_i) begin
          a_d     = radicand_i;
          acc_d   = '0;
          cnt_d   = LastBit;
          iters_d = '0;
          if (radicand_i == '0) begin
            x_d     = '0;
            conv_d  = 1'b1;
            state_d = nsr_pkg::ST_OUT;
          end else begin
            x_d     = OneFx;
            state_d = nsr_pkg::ST_MUL;
          end
        end
      end

      // Multiplier bits are taken from the top down: acc = 2*acc + bit*x.
      nsr_pkg::ST_MUL: begin
        unit_a = UW'({acc_q, 1'b0});
        unit_b = UW'(x_bit_term);
        acc_d  = unit_sum[PW-1:0];
        cnt_d  = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = nsr_pkg::ST_DIFF;
        end
      end

      nsr_pkg::ST_DIFF: begin
        unit_a   = UW'(acc_q[PW-1:FRAC_BITS]);
        unit_b   = UW'(a_q);
        unit_sub = 1'b1;
        mag_d    = unit_sum[MB-1:0];
        neg_d    = unit_sum[UW-1];
        state_d  = unit_sum[UW-1] ? nsr_pkg::ST_NEG : nsr_pkg::ST_SAT;
      end

      nsr_pkg::ST_NEG: begin
        unit_b   = UW'(mag_q);
        unit_sub = 1'b1;
        mag_d    = unit_sum[MB-1:0];
        state_d  = nsr_pkg::ST_SAT;
      end

      // The quotient reaches 2^W exactly when the upper part of the shifted
      // dividend is not below the divisor; then it saturates.
      nsr_pkg::ST_SAT: begin
        unit_a   = UW'(mag_q[MB-1:INT_BITS]);
        unit_b   = UW'(den);
        unit_sub = 1'b1;
        rem_d    = {1'b0, mag_q[MB-1:INT_BITS]};
        nbits_d  = {mag_q[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
        quot_d   = '0;
        cnt_d    = LastBit;
        if (!unit_sum[UW-1]) begin
          quot_d  = WMask;
          state_d = nsr_pkg::ST_UPD;
        end else begin
          state_d = nsr_pkg::ST_DIV;
        end
      end

      nsr_pkg::ST_DIV: begin
        unit_a   = UW'({rem_q, nbits_q[W-1]});
        unit_b   = UW'(den);
        unit_sub = 1'b1;
        if (!unit_sum[UW-1]) begin
          rem_d  = unit_sum[W:0];
          quot_d = {quot_q[W-2:0], 1'b1};
        end else begin
          rem_d  = {rem_q[W-1:0], nbits_q[W-1]};
          quot_d = {quot_q[W-2:0], 1'b0};
        end
        nbits_d = {nbits_q[W-2:0], 1'b0};
        cnt_d   = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = nsr_pkg::ST_UPD;
        end
      end

      // The estimate is kept between 1 and the all-ones word.
      nsr_pkg::ST_UPD: begin
        unit_a   = UW'(x_q);
        unit_b   = UW'(quot_q);
        unit_sub = !neg_q;
        if (neg_q) begin
          nx_d = unit_sum[W] ? WMask : unit_sum[W-1:0];
        end else if (unit_sum[UW-1] || (unit_sum[W-1:0] == '0)) begin
          nx_d = W'(1);
        end else begin
          nx_d = unit_sum[W-1:0];
        end
        state_d = nsr_pkg::ST_CHG;
      end

      nsr_pkg::ST_CHG: begin
        unit_a   = neg_q ? UW'(nx_q) : UW'(x_q);
        unit_b   = neg_q ? UW'(x_q) : UW'(nx_q);
        unit_sub = 1'b1;
        x_d      = nx_q;
        iters_d  = iters_inc;
        conv_d   = tol_met;
        acc_d    = '0;
        cnt_d    = LastBit;
        if (tol_met || (iters_inc >= lim_eff)) begin
          state_d = nsr_pkg::ST_OUT;
        end else begin
          state_d = nsr_pkg::ST_MUL;
        end
      end

      nsr_pkg::ST_OUT: begin
        if (out_free_i) begin
          done    = 1'b1;
          state_d = nsr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = nsr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nsr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    x_q     <= x_d;
    nx_q    <= nx_d;
    acc_q   <= acc_d;
    mag_q   <= mag_d;
    rem_q   <= rem_d;
    nbits_q <= nbits_d;
    quot_q  <= quot_d;
    neg_q   <= neg_d;
    conv_q  <= conv_d;
    cnt_q   <= cnt_d;
    iters_q <= iters_d;
  end

  assign status_o.idle = (state_q == nsr_pkg::ST_IDLE);
  assign status_o.done = done;
  assign root_o        = x_q;
  assign iters_o       = iters_q;
  assign conv_o        = conv_q;

endmodule

>>> design/newton_square_root.sv
// Sequence: a zero radicand goes straight from the idle state to the output state.
// Otherwise each Newton iteration runs a bit-serial multiply and divide over the
// W = INT_BITS+FRAC_BITS bits (32 at Q16.16) on the one shared adder-subtractor;
// up to iteration_limit iterations run before the result is handed over.
// Throughput: one request at a time; the next is taken once the sequencer is idle again.
// Reset: asynchronous, active low; clears control state and sets tolerance 1, limit 55.
// ----------------------------------------------------------------------------
// Newton square root
// Fixed-point square root by Newton iteration with a stream interface.
// ----------------------------------------------------------------------------
module newton_square_root #(
  parameter int unsigned INT_BITS  = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration writes.
  input  logic                              cfg_we_i,
  input  logic [nsr_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [nsr_pkg::CfgDataW-1:0]      cfg_data_i,
  // Input stream.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [nsr_pkg::RadicandW-1:0]     s_axis_tdata_i,  // [31:0] radicand
  // Output stream.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [31:0] root, [37:32] iterations_used, [38] converged, [39] zero fill
  output logic [nsr_pkg::OutDataW-1:0]      m_axis_tdata_o
);

  localparam int unsigned W = INT_BITS + FRAC_BITS;

  logic [nsr_pkg::TolW-1:0]     tol_q;
  logic [nsr_pkg::LimW-1:0]     lim_q;

  logic                         out_valid_q;
  logic [nsr_pkg::RootW-1:0]    out_root_q;
  logic [nsr_pkg::LimW-1:0]     out_iters_q;
  logic                         out_conv_q;

  nsr_pkg::nsr_status_t         status;
  logic [W-1:0]                 core_root;
  logic [nsr_pkg::LimW-1:0]     core_iters;
  logic                         core_conv;
  logic                         out_free;
  logic                         start;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign start    = s_axis_tvalid_i && s_axis_tready_o;

  nsr_core #(
    .INT_BITS (INT_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .radicand_i(W'(s_axis_tdata_i)),
    .tol_i     (tol_q),
    .lim_i     (lim_q),
    .out_free_i(out_free),
    .status_o  (status),
    .root_o    (core_root),
    .iters_o   (core_iters),
    .conv_o    (core_conv)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= nsr_pkg::TOL_RESET;
      lim_q <= nsr_pkg::LIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nsr_pkg::CFG_TOLERANCE:  tol_q <= cfg_data_i[nsr_pkg::TolW-1:0];
        nsr_pkg::CFG_ITER_LIMIT: lim_q <= cfg_data_i[nsr_pkg::LimW-1:0];
      endcase
    end
  end

  // The output register frees the sequencer as soon as a result is handed over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (status.done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (status.done) begin
      out_root_q  <= nsr_pkg::RootW'(core_root);
      out_iters_q <= core_iters;
      out_conv_q  <= core_conv;
    end
  end

  assign s_axis_tready_o = status.idle;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_conv_q, out_iters_q, out_root_q};

endmodule
